// ===== hdl/kvt_pkg.sv =====
// shared types, constants and hash function for the key-value table with global add
// no dependencies
package kvt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BITS = 32;
  localparam int KEY_W = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int IDX_W = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENTRY_W = KEY_W + 32;

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_GET = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_ADD = 3'd3;
  localparam logic [2:0] MODE_ADD_ALL = 3'd4;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_ABSENT = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [2:0] mode;
    logic [31:0] key;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic found;
    logic [1:0] status;
  } result_t;

  // xor fold of the key onto the index bits, then folded into the table range
  function automatic logic [IDX_W-1:0] key_home(input logic [KEY_W-1:0] k);
    logic [IDX_W-1:0] h;
    logic [IDX_W:0] wide;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ k[i];
    end
    wide = {1'b0, h};
    if (wide >= (IDX_W+1)'(TABLE_DEPTH)) begin
      wide = wide - (IDX_W+1)'(TABLE_DEPTH);
    end
    return wide[IDX_W-1:0];
  endfunction

endpackage

// ===== hdl/kvt_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
module kvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== hdl/key_value_table_with_global_add_unit.sv =====
// top level of the key-value table with a lazy global offset
// depends on kvt_pkg and kvt_ram
//
// Keys and stored values live in one single-port ram, placed by an xor-fold
// hash with linear probing; per-slot valid and deleted marks are flip-flops
// cleared at reset, so no clearing pass is needed. Every visible value is the
// stored value plus a global offset, so add-to-all only updates the offset.
// An item that touches the table makes P probes (one ram read and one compare
// each), then a write step, then its result beat: P is 1 with no collision,
// at most TABLE_DEPTH; slots freed by delete keep a mark that lengthens later
// probe chains. Add-to-all and unused modes go straight to the result beat.
// A new item is accepted while the previous result beat still waits.
module key_value_table_with_global_add_unit
  import kvt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_WRITE,
    S_DONE
  } state_t;

  state_t state;

  logic [2:0] mode;
  logic [KEY_W-1:0] key;
  logic [31:0] value;
  logic [31:0] offset;

  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [TABLE_DEPTH-1:0] slot_tomb;

  logic [IDX_W-1:0] probe;
  logic [IDX_W-1:0] probes;
  logic [IDX_W-1:0] free_slot;
  logic free_ok;
  logic [IDX_W-1:0] hit_slot;
  logic hit;
  logic [31:0] stored;

  logic [31:0] res_base;
  logic res_add_off;
  logic res_found;
  logic [1:0] res_status;

  logic ram_en;
  logic ram_we;
  logic [IDX_W-1:0] ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_DEPTH - 1);

  logic cur_valid;
  logic cur_hit;
  logic cur_empty;
  logic [IDX_W-1:0] free_slot_next;
  logic free_ok_next;
  logic [IDX_W-1:0] probe_next;
  logic [31:0] new_stored;
  logic do_write;
  logic [IDX_W-1:0] write_slot;

  always_comb begin
    cur_valid = slot_valid[probe];
    cur_hit = cur_valid && (ram_rdata[ENTRY_W-1:32] == key);
    cur_empty = !cur_valid && !slot_tomb[probe];
    free_ok_next = free_ok || !cur_valid;
    free_slot_next = free_ok ? free_slot : probe;
    probe_next = (probe == LAST) ? '0 : probe + 1'b1;
  end

  // value to store and where, for the write step
  always_comb begin
    new_stored = '0;
    do_write = 1'b0;
    write_slot = hit ? hit_slot : free_slot;
    case (mode)
      MODE_INSERT: begin
        new_stored = value - offset;
        do_write = hit || free_ok;
      end
      MODE_ADD: begin
        new_stored = hit ? stored + value : value;
        do_write = hit || free_ok;
      end
      default: begin
        new_stored = stored;
        do_write = 1'b0;
      end
    endcase
  end

  always_comb begin
    ram_en = 1'b0;
    ram_we = 1'b0;
    ram_addr = probe;
    ram_wdata = {key, new_stored};
    case (state)
      S_READ: begin
        ram_en = 1'b1;
      end
      S_WRITE: begin
        ram_en = do_write;
        ram_we = do_write;
        ram_addr = write_slot;
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  kvt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      offset <= '0;
      slot_valid <= '0;
      slot_tomb <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            mode <= item.mode;
            key <= item.key[KEY_W-1:0];
            value <= item.value;
            probe <= key_home(item.key[KEY_W-1:0]);
            probes <= '0;
            free_ok <= 1'b0;
            hit <= 1'b0;
            res_found <= 1'b0;
            res_status <= STATUS_OK;
            res_add_off <= 1'b0;
            case (item.mode)
              MODE_INSERT, MODE_GET, MODE_DELETE, MODE_ADD: begin
                state <= S_READ;
              end
              MODE_ADD_ALL: begin
                offset <= offset + item.value;
                res_base <= offset + item.value;
                state <= S_DONE;
              end
              default: begin
                res_base <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          free_ok <= free_ok_next;
          free_slot <= free_slot_next;
          if (cur_hit) begin
            hit <= 1'b1;
            hit_slot <= probe;
            stored <= ram_rdata[31:0];
            state <= S_WRITE;
          end else if (cur_empty || probes == LAST) begin
            state <= S_WRITE;
          end else begin
            probe <= probe_next;
            probes <= probes + 1'b1;
            state <= S_READ;
          end
        end
        S_WRITE: begin
          res_found <= hit;
          state <= S_DONE;
          case (mode)
            MODE_INSERT, MODE_ADD: begin
              if (hit || free_ok) begin
                res_base <= new_stored;
                res_add_off <= 1'b1;
                slot_valid[write_slot] <= 1'b1;
                slot_tomb[write_slot] <= 1'b0;
              end else begin
                res_base <= '0;
                res_status <= STATUS_FULL;
              end
            end
            default: begin
              res_add_off <= 1'b1;
              if (hit) begin
                res_base <= stored;
                if (mode == MODE_DELETE) begin
                  slot_valid[hit_slot] <= 1'b0;
                  slot_tomb[hit_slot] <= 1'b1;
                end
              end else begin
                res_base <= '0;
                res_status <= STATUS_ABSENT;
              end
            end
          endcase
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            result.result_value <= res_add_off ? res_base + offset : res_base;
            result.found <= res_found;
            result.status <= res_status;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
